@@ src/sorted_set_insert_delete_core_assert.svh @@
// Assertion macros for the sorted set core.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef SORTED_SET_INSERT_DELETE_CORE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSID_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ssid_pkg.sv @@
// Shared types and constants of the sorted set core.
// No dependencies; used by the controller, datapath and top level.
package ssid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;

    // Request operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;   // capture request fields
        logic cmp;    // register per-cell compare flags
        logic upd;    // shift cells, update count, register result
    } t_ctrl_cmd;

endpackage

@@ src/ssid_ctrl.sv @@
// Sequencer of the sorted set core: request capture, compare and update steps.
// Depends on ssid_pkg.
module ssid_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output ssid_pkg::t_ctrl_cmd   o_cmd,
    output logic                  o_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;
    logic       accept;

    assign busy   = (r_state == S_CMP);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = accept ? S_CMP : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_UPD);
        end
    end

    assign o_cmd.load = accept;
    assign o_cmd.cmp  = (r_state == S_CMP);
    assign o_cmd.upd  = (r_state == S_UPD);
    assign o_valid    = r_valid;

endmodule

@@ src/ssid_datapath.sv @@
// Datapath of the sorted set core: a row of entry cells with per-cell compare and shift.
// Depends on ssid_pkg.
module ssid_datapath #(
    parameter int CAPACITY = ssid_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ssid_pkg::t_ctrl_cmd                  i_cmd,
    input  logic                                 i_func,
    input  logic signed [ssid_pkg::VALUE_W-1:0]  i_value,
    output logic        [ssid_pkg::STATUS_W-1:0] o_status,
    output logic        [ssid_pkg::COUNT_W-1:0]  o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                                r_func;
    logic signed [ssid_pkg::VALUE_W-1:0] r_value;
    logic signed [ssid_pkg::VALUE_W-1:0] r_entry [CAPACITY];
    logic [CAPACITY-1:0]                 r_valid;   // thermometer of occupied cells
    logic [CAPACITY-1:0]                 r_lt;
    logic [CAPACITY-1:0]                 r_eq;
    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic [ssid_pkg::STATUS_W-1:0]       r_status;
    logic [ssid_pkg::STATUS_W-1:0]       n_status;
    logic [CW+ssid_pkg::COUNT_W-1:0]     count_ext;
    logic                                present;
    logic                                full;
    logic                                do_ins;
    logic                                do_del;

    // Capture request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

    // Compare every occupied cell against the key in parallel
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_lt[i] <= r_valid[i] && (r_entry[i] < r_value);
                r_eq[i] <= r_valid[i] && (r_entry[i] == r_value);
            end
        end
    end

    assign present = |r_eq;
    assign full    = r_valid[CAPACITY-1];
    assign do_ins  = i_cmd.upd && (r_func == ssid_pkg::FUNC_INSERT) && !present && !full;
    assign do_del  = i_cmd.upd && (r_func == ssid_pkg::FUNC_DELETE) && present;

    always_comb begin
        n_count  = r_count;
        n_status = ssid_pkg::ST_INSERTED;
        if (r_func == ssid_pkg::FUNC_INSERT) begin
            if (present) begin
                n_status = ssid_pkg::ST_DUPLICATE;
            end else if (full) begin
                n_status = ssid_pkg::ST_FULL;
            end else begin
                n_status = ssid_pkg::ST_INSERTED;
                n_count  = r_count + {{(CW-1){1'b0}}, 1'b1};
            end
        end else begin
            if (present) begin
                n_status = ssid_pkg::ST_DELETED;
                n_count  = r_count - {{(CW-1){1'b0}}, 1'b1};
            end else begin
                n_status = ssid_pkg::ST_NOT_FOUND;
            end
        end
    end

    // Cells below the key hold; the rest shift up on insert or down on delete
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (do_ins && !r_lt[gi]) begin
                if (gi == 0) begin
                    r_entry[gi] <= r_value;
                end else if (r_lt[(gi == 0) ? 0 : gi-1]) begin
                    r_entry[gi] <= r_value;
                end else begin
                    r_entry[gi] <= r_entry[(gi == 0) ? 0 : gi-1];
                end
            end else if (do_del && !r_lt[gi] && (gi < CAPACITY-1)) begin
                r_entry[gi] <= r_entry[(gi < CAPACITY-1) ? gi+1 : gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
            if (do_ins) begin
                r_valid <= {r_valid[CAPACITY-2:0], 1'b1};
            end else if (do_del) begin
                r_valid <= {1'b0, r_valid[CAPACITY-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_status <= n_status;
        end
    end

    // Report the count modulo 128
    assign count_ext = {{ssid_pkg::COUNT_W{1'b0}}, r_count};
    assign o_count   = count_ext[ssid_pkg::COUNT_W-1:0];
    assign o_status  = r_status;

endmodule

@@ src/sorted_set_insert_delete_core.sv @@
// Top level of the sorted set core: controller plus cell-array datapath.
// Depends on ssid_pkg, ssid_ctrl, ssid_datapath and the assertion macro header.
//
// Sorted set of distinct signed 32-bit keys, up to CAPACITY entries, kept in
// ascending order in a row of register cells. A request is accepted at a
// rising edge with start high and busy low; i_func selects insert or delete.
// Each request has a compare step, where every cell compares its key against
// the request value in parallel and the flags are registered, and an update
// step, where the cells at and above the sorted position shift up (insert)
// or down (delete) in one step. busy is high for the single compare cycle
// after an accept, so a new request may be accepted in the update step of the
// previous one. The result (o_status, o_count) is presented for exactly one
// cycle with o_valid high; the receiver cannot stall it and must take it in
// that cycle. Status: inserted, duplicate, deleted, not found, full (a
// duplicate is reported ahead of full). o_count is the entry count after the
// request, modulo 128. Cell contents need no clearing after reset; occupancy
// is tracked separately, so the block is ready right after reset.
`include "sorted_set_insert_delete_core_assert.svh"

module sorted_set_insert_delete_core #(
    parameter int CAPACITY = ssid_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_func,
    input  logic signed [ssid_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    output logic        [ssid_pkg::STATUS_W-1:0] o_status,
    output logic        [ssid_pkg::COUNT_W-1:0]  o_count
);

    ssid_pkg::t_ctrl_cmd cmd;

    // Sequence capture, compare and update
    ssid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    // Hold the cells, compare, shift and form the result
    ssid_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_func   (i_func),
        .i_value  (i_value),
        .o_status (o_status),
        .o_count  (o_count)
    );

    // An accepted request occupies exactly one compare cycle
    `SSID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy missing after accept")
    `SSID_ASSERT_NEXT(a_busy_one, busy, !busy, "compare step lasted more than one cycle")
    // Each accepted request yields a result strobe after its compare and update steps
    `SSID_ASSERT_NEXT(a_result_lat, start && !busy, ##2 o_valid, "result strobe missing")
    // The update step never overlaps the compare step
    `SSID_ASSERT_SAME(a_cmd_excl, 1'b1, !(cmd.cmp && cmd.upd), "compare and update overlap")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for sorted_set_insert_delete_core.
// Depends on ssid_pkg and the core RTL; drives insert and delete requests and
// checks every status and count against a behavioral copy of the sorted set.

typedef struct packed {
    logic [ssid_pkg::STATUS_W-1:0] status;
    logic [ssid_pkg::COUNT_W-1:0]  count;
} t_set_outcome;

class sorted_set_tracker;
    logic signed [ssid_pkg::VALUE_W-1:0] keys [ssid_pkg::CAPACITY_DEF];
    int           n_keys;
    int           errors;
    t_set_outcome due_outcomes [$];

    function new();
        n_keys = 0;
        errors = 0;
    endfunction

    // Apply one accepted request to the shadow set and queue its outcome.
    function void note_request(logic func, logic signed [ssid_pkg::VALUE_W-1:0] value);
        int           pos;
        int           i;
        bit           present;
        t_set_outcome outcome;
        pos = 0;
        while (pos < n_keys && keys[pos] < value)
            pos++;
        present = (pos < n_keys) && (keys[pos] == value);
        if (func == ssid_pkg::FUNC_INSERT) begin
            if (present) begin
                outcome.status = ssid_pkg::ST_DUPLICATE;
            end else if (n_keys >= ssid_pkg::CAPACITY_DEF) begin
                outcome.status = ssid_pkg::ST_FULL;
            end else begin
                for (i = n_keys; i > pos; i--)
                    keys[i] = keys[i-1];
                keys[pos] = value;
                n_keys++;
                outcome.status = ssid_pkg::ST_INSERTED;
            end
        end else begin
            if (!present) begin
                outcome.status = ssid_pkg::ST_NOT_FOUND;
            end else begin
                for (i = pos; i + 1 < n_keys; i++)
                    keys[i] = keys[i+1];
                n_keys--;
                outcome.status = ssid_pkg::ST_DELETED;
            end
        end
        outcome.count = 7'(n_keys);
        due_outcomes.push_back(outcome);
    endfunction

    // Compare one result against the oldest queued outcome.
    function void check_result(logic [ssid_pkg::STATUS_W-1:0] status,
                               logic [ssid_pkg::COUNT_W-1:0] count);
        t_set_outcome want;
        if (due_outcomes.size() == 0) begin
            $error("unexpected result: status %0d, count %0d", status, count);
            errors++;
            return;
        end
        want = due_outcomes.pop_front();
        if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, count);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int CAP         = ssid_pkg::CAPACITY_DEF;
    localparam int MAX_GAP     = 40;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 6;

    localparam logic signed [ssid_pkg::VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [ssid_pkg::VALUE_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic                                 i_func;
    logic signed [ssid_pkg::VALUE_W-1:0]  i_value;
    logic                                 o_valid;
    logic        [ssid_pkg::STATUS_W-1:0] o_status;
    logic        [ssid_pkg::COUNT_W-1:0]  o_count;

    sorted_set_tracker tracker;
    int                quiet_cycles = 0;
    bit                filling = 1'b1;
    int                full_hits = 0;

    sorted_set_insert_delete_core #(.CAPACITY(CAP)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_func),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_count  (o_count)
    );

    always #1 i_clk = ~i_clk;

    // Issue one request after a random idle gap and hold it until the core
    // takes it. Start stays high when the next request follows at once, so
    // it is never dropped and raised in the same step.
    task automatic issue_request(input logic func,
                                 input logic signed [ssid_pkg::VALUE_W-1:0] value,
                                 input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= func;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        // Accepted at this edge: advance the shadow set right away so the
        // next pick sees the current contents.
        tracker.note_request(func, value);
    endtask

    // Pick a key: deletes mostly hit a stored key, inserts mostly bring new
    // ones; the rest mixes a narrow band (many collisions), extremes and
    // fully random words.
    function automatic logic signed [ssid_pkg::VALUE_W-1:0] pick_value(logic func);
        int                                  roll;
        int                                  stored_pct;
        logic signed [ssid_pkg::VALUE_W-1:0] key;
        stored_pct = (func == ssid_pkg::FUNC_DELETE) ? 80 : 10;
        roll = $urandom_range(99);
        if (tracker.n_keys > 0 && roll < stored_pct)
            return tracker.keys[$urandom_range(tracker.n_keys - 1)];
        roll = $urandom_range(99);
        if (roll < 30) begin
            key = $signed(32'($urandom_range(40))) - 20;
        end else if (roll < 40) begin
            case ($urandom_range(5))
                0:       key = KEY_MIN;
                1:       key = KEY_MAX;
                2:       key = KEY_MIN + 1;
                3:       key = KEY_MAX - 1;
                4:       key = -1;
                default: key = 0;
            endcase
        end else begin
            key = $urandom;
        end
        return key;
    endfunction

    // Alternate between filling the store up to full (and lingering there so
    // full and duplicate-at-full both show up) and draining it back to empty.
    task automatic run_phase(input int n_items, input int idle_pct);
        logic func;
        repeat (n_items) begin
            if (filling && tracker.n_keys == CAP) begin
                full_hits++;
                if (full_hits >= 8)
                    filling = 1'b0;
            end else if (!filling && tracker.n_keys == 0) begin
                filling   = 1'b1;
                full_hits = 0;
            end
            if ($urandom_range(99) < (filling ? 90 : 10))
                func = ssid_pkg::FUNC_INSERT;
            else
                func = ssid_pkg::FUNC_DELETE;
            issue_request(func, pick_value(func), idle_pct);
        end
    endtask

    // Check every result at the edge that ends its strobe cycle; drop out
    // on a stretch with no request and no result accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                tracker.check_result(o_status, o_count);
            if ((start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        tracker = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_func  <= ssid_pkg::FUNC_INSERT;
        i_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, extremes of the key range, duplicates,
        // misses, removal at head, tail and middle, back to empty.
        issue_request(ssid_pkg::FUNC_DELETE, 0, 0);
        issue_request(ssid_pkg::FUNC_INSERT, 0, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MAX, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MIN, 0);
        issue_request(ssid_pkg::FUNC_INSERT, -1, 0);
        issue_request(ssid_pkg::FUNC_INSERT, 1, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MAX, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MIN, 0);
        issue_request(ssid_pkg::FUNC_DELETE, 5, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MIN, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MAX, 0);
        issue_request(ssid_pkg::FUNC_DELETE, 0, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MIN + 1, 0);
        issue_request(ssid_pkg::FUNC_INSERT, KEY_MAX - 1, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MAX, 0);
        issue_request(ssid_pkg::FUNC_DELETE, -1, 0);
        issue_request(ssid_pkg::FUNC_DELETE, 1, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MIN + 1, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MAX - 1, 0);
        issue_request(ssid_pkg::FUNC_DELETE, KEY_MIN, 0);

        // Random: light sender idling, then heavy, then back to back.
        run_phase(134, 36);
        run_phase(134, 79);
        run_phase(134, 0);

        // Release start, let every outcome drain, then watch a few more
        // cycles for stray results.
        start <= 1'b0;
        while (tracker.due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.due_outcomes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
